### rtl/core/png_cf_pkg.sv
package png_cf_pkg;

  localparam int unsigned MaxResults = 12;
  localparam int unsigned CntW       = 4;

  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_CHUNK   = 2'd1,
    STATUS_CHUNK_OPEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] crc;
    logic [30:0] remaining;
    logic        open;
  } frame_state_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [CntW-1:0]            count;
    status_e                    status;
  } result_set_t;

  localparam frame_state_t ResetState = '{crc: CrcPreset, remaining: '0, open: 1'b0};

  // Reflected CRC-32, one byte folded in.
  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/png_cf_in_if.sv
interface png_cf_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] chunk_type;
  logic [30:0] chunk_length;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, chunk_type, chunk_length, data_byte, input ready);
  modport sink   (input valid, cmd, chunk_type, chunk_length, data_byte, output ready);
endinterface

### rtl/core/png_cf_out_if.sv
interface png_cf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [1:0] status;

  modport source (output valid, out_byte, last_of_run, status, input ready);
  modport sink   (input valid, out_byte, last_of_run, status, output ready);
endinterface

### rtl/core/png_cf_step.sv
module png_cf_step (
  input  logic                       cmd_i,
  input  logic [31:0]                chunk_type_i,
  input  logic [30:0]                chunk_length_i,
  input  logic [7:0]                 data_byte_i,
  input  png_cf_pkg::frame_state_t   state_i,
  output png_cf_pkg::frame_state_t   state_o,
  output png_cf_pkg::result_set_t    results_o
);
  import png_cf_pkg::*;

  logic [31:0] type_crc;
  logic [31:0] data_crc;
  logic [31:0] len_word;
  logic [30:0] rem_dec;

  always_comb begin
    type_crc = crc_fold(crc_fold(crc_fold(crc_fold(CrcPreset, chunk_type_i[31:24]),
                                          chunk_type_i[23:16]),
                                 chunk_type_i[15:8]),
                        chunk_type_i[7:0]);
    data_crc = crc_fold(state_i.crc, data_byte_i);
    rem_dec  = state_i.remaining - 31'd1;
    len_word = {1'b0, chunk_length_i};

    state_o           = state_i;
    results_o.bytes   = '0;
    results_o.count   = CntW'(1);
    results_o.status  = STATUS_OK;

    unique case (cmd_e'(cmd_i))
      CMD_BEGIN: begin
        if (state_i.open) begin
          results_o.status = STATUS_CHUNK_OPEN;
        end else begin
          for (int i = 0; i < 4; i++) begin
            results_o.bytes[i]     = len_word[31-8*i -: 8];
            results_o.bytes[4 + i] = chunk_type_i[31-8*i -: 8];
          end
          state_o.crc = type_crc;
          if (chunk_length_i == '0) begin
            for (int i = 0; i < 4; i++) begin
              results_o.bytes[8 + i] = ~type_crc[31-8*i -: 8];
            end
            results_o.count   = CntW'(MaxResults);
            state_o.open      = 1'b0;
            state_o.remaining = '0;
          end else begin
            results_o.count   = CntW'(8);
            state_o.open      = 1'b1;
            state_o.remaining = chunk_length_i;
          end
        end
      end
      CMD_DATA: begin
        if (!state_i.open) begin
          results_o.status = STATUS_NO_CHUNK;
        end else begin
          results_o.bytes[0] = data_byte_i;
          state_o.crc        = data_crc;
          state_o.remaining  = rem_dec;
          if (rem_dec == '0) begin
            // final byte closes the chunk: append inverted CRC
            for (int i = 0; i < 4; i++) begin
              results_o.bytes[1 + i] = ~data_crc[31-8*i -: 8];
            end
            results_o.count = CntW'(5);
            state_o.open    = 1'b0;
          end
        end
      end
      default: begin
        results_o.status = STATUS_OK;
      end
    endcase
  end

endmodule

### rtl/core/png_cf_ser.sv
module png_cf_ser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  png_cf_pkg::result_set_t results_i,
  output logic                    ready_o,
  png_cf_out_if.source            out_o
);
  import png_cf_pkg::*;

  logic [MaxResults-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  status_e                    status_q, status_d;
  logic                       pop;

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = bytes_q[0];
  assign out_o.last_of_run = (cnt_q == CntW'(1));
  assign out_o.status      = status_q;

  assign pop     = out_o.valid && out_o.ready;
  // free once the last pending byte leaves this cycle
  assign ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_o.ready);

  always_comb begin
    bytes_d  = bytes_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    priority if (load_i) begin
      bytes_d  = results_i.bytes;
      cnt_d    = results_i.count;
      status_d = results_i.status;
    end else if (pop) begin
      bytes_d = bytes_q >> 8;
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    status_q <= status_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxResults))
    else $error("result count overran the buffer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_o.valid && status_q != STATUS_OK) |-> out_o.last_of_run)
    else $error("flagged request produced more than one result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> ready_o)
    else $error("load while results still pending");

endmodule

### rtl/core/png_chunk_framer_crc32.sv
// PNG chunk framer with CRC-32.
// in_i  : request channel. cmd=begin carries chunk_type and chunk_length; the
//         block answers with the 4 length bytes (big-endian) and the 4 type
//         bytes, plus the inverted CRC when the length is zero. cmd=data
//         carries one byte, passed through and folded into the CRC; the final
//         byte of the chunk is followed by the 4 inverted CRC bytes.
// out_o : one byte per transfer; last_of_run marks the final byte of each
//         request, status flags data with no open chunk or a begin while
//         bytes remain (those give a single zero byte, state untouched).
// Latency: first result byte is valid the cycle after the request is taken.
// Throughput: requests are taken when the result buffer holds at most one
//   byte that leaves this cycle, so data bytes stream at 1 per clock while
//   out_o.ready stays high; a begin yields 8 result bytes (12 for an empty
//   chunk), a closing data byte 5. The CRC update is a combinational byte fold.
// Reset: CRC preset to all ones, no chunk open, result buffer empty.
// Stall: when out_o.ready is low the current byte holds and in_i.ready drops
//   as soon as the pending byte cannot leave.
module png_chunk_framer_crc32 (
  input  logic         clk_i,
  input  logic         rst_ni,
  png_cf_in_if.sink    in_i,
  png_cf_out_if.source out_o
);
  import png_cf_pkg::*;

  frame_state_t state_q, state_d;
  result_set_t  results;
  logic         accept;
  logic         ser_ready;

  assign in_i.ready = ser_ready;
  assign accept     = in_i.valid && ser_ready;

  // per-request state update and result bytes
  png_cf_step u_step (
    .cmd_i          (in_i.cmd),
    .chunk_type_i   (in_i.chunk_type),
    .chunk_length_i (in_i.chunk_length),
    .data_byte_i    (in_i.data_byte),
    .state_i        (state_q),
    .state_o        (state_d),
    .results_o      (results)
  );

  // result buffer, drained one byte per transfer
  png_cf_ser u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .results_i (results),
    .ready_o   (ser_ready),
    .out_o     (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ResetState;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q.open |-> (state_q.remaining != '0))
    else $error("open chunk with no bytes remaining");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !state_q.open |-> (state_q.remaining == '0))
    else $error("bytes remaining with no open chunk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && in_i.cmd == CMD_BEGIN && !state_q.open &&
                    in_i.chunk_length != '0) |=> state_q.open)
    else $error("begin with nonzero length did not open a chunk");

endmodule

### test/png_chunk_framer_crc32_tb.sv
`timescale 1ns / 100ps

module png_chunk_framer_crc32_tb;
  import png_cf_pkg::*;

  // Idle cycles with no transfer on either channel before the run is called hung.
  // Sender gaps and sink stalls share one bound, set by pick_gap.
  localparam int unsigned HangLimit = 2000;
  // Cycles to watch for stray output once the queue has drained.
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandomRequests = 120;

  // One request as driven on the input channel. A row with use_flag set
  // carries its own expected answer: a single zero byte with flag_status.
  typedef struct {
    cmd_e        cmd;
    logic [31:0] ctype;
    logic [30:0] clen;
    logic [7:0]  dbyte;
    bit          use_flag;
    status_e     flag_status;
  } chunk_req_t;

  // One expected byte of the framed stream.
  typedef struct {
    logic [7:0] value;
    logic       last;
    status_e    status;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni;

  png_cf_in_if  req_if ();
  png_cf_out_if res_if ();

  png_chunk_framer_crc32 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Predictor state: running CRC, bytes left in the open chunk, open flag.
  logic [31:0] frame_crc;
  logic [30:0] frame_left;
  logic        frame_open;

  frame_byte_t framed_q[$];   // expected output bytes, oldest first
  int unsigned n_fail;
  int unsigned idle_cycles;
  bit          send_burst;    // sender runs without gaps while set

  chunk_req_t directed_tbl [21];
  chunk_req_t tail_tbl [4];

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Reflected CRC-32, bit-serial form: feedback is crc LSB xor data bit.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    framed_q.push_back('{value: v, last: 1'b0, status: STATUS_OK});
  endfunction

  // Big-endian, MSB byte first.
  function automatic void push_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) begin
      push_byte(w[8*k +: 8]);
    end
  endfunction

  // Rejected request: one zero byte, marked last, with an error status.
  function automatic void push_flag(status_e st);
    framed_q.push_back('{value: 8'h00, last: 1'b1, status: st});
  endfunction

  function automatic void frame_chunk_req(chunk_req_t r);
    logic [31:0] c;
    if (r.cmd == CMD_BEGIN) begin
      if (frame_open) begin
        push_flag(STATUS_CHUNK_OPEN);
        return;
      end
      push_word({1'b0, r.clen});
      push_word(r.ctype);
      c = CrcPreset;
      for (int k = 3; k >= 0; k--) begin
        c = crc32_byte(c, r.ctype[8*k +: 8]);
      end
      frame_crc = c;
      if (r.clen == '0) begin
        // empty chunk closes at once
        push_word(~frame_crc);
        frame_open = 1'b0;
        frame_left = '0;
      end else begin
        frame_open = 1'b1;
        frame_left = r.clen;
      end
    end else begin
      if (!frame_open) begin
        push_flag(STATUS_NO_CHUNK);
        return;
      end
      push_byte(r.dbyte);
      frame_crc  = crc32_byte(frame_crc, r.dbyte);
      frame_left = frame_left - 31'd1;
      if (frame_left == '0) begin
        push_word(~frame_crc);
        frame_open = 1'b0;
      end
    end
    framed_q[framed_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one request and wait for the handshake. valid stays high after
  // acceptance so back-to-back requests need no extra edge.
  task automatic send_req(input chunk_req_t r);
    int unsigned gap;
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= r.cmd;
    req_if.chunk_type   <= r.ctype;
    req_if.chunk_length <= r.clen;
    req_if.data_byte    <= r.dbyte;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (r.use_flag) push_flag(r.flag_status);
    else frame_chunk_req(r);
  endtask

  // Sender holds off until every expected byte has left the block.
  // Always waits for a clock edge before checking, so valid is never lowered and raised
  // in the same step.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (framed_q.size() != 0);
  endtask

  function automatic chunk_req_t rand_req(cmd_e cmd, logic [30:0] len);
    chunk_req_t r;
    r.cmd         = cmd;
    r.ctype       = $urandom;
    r.clen        = len;
    r.dbyte       = $urandom_range(0, 255);
    r.use_flag    = 1'b0;
    r.flag_status = STATUS_OK;
    return r;
  endfunction

  // Random chunk length: some empty, most short, a few longer.
  function automatic logic [30:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return 31'($urandom_range(1, 6));
    return 31'($urandom_range(7, 40));
  endfunction

  // ---------------------------------------------------------------------------
  // Output sink: random backpressure, with long runs of ready too
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hi;
    int unsigned lo;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      lo = pick_gap();
      res_if.ready <= 1'b1;
      repeat (hi) @(posedge clk_i);
      if (lo > 0) begin
        res_if.ready <= 1'b0;
        repeat (lo) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: each accepted byte against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_out
    frame_byte_t exp_b;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (framed_q.size() == 0) begin
        $error("unexpected output byte %02h last %0d status %0d",
               res_if.out_byte, res_if.last_of_run, res_if.status);
        n_fail++;
      end else begin
        exp_b = framed_q.pop_front();
        if (res_if.out_byte !== exp_b.value) begin
          $error("out_byte: expected %02h, got %02h", exp_b.value, res_if.out_byte);
          n_fail++;
        end
        if (res_if.last_of_run !== exp_b.last) begin
          $error("last_of_run: expected %0d, got %0d", exp_b.last, res_if.last_of_run);
          n_fail++;
        end
        if (res_if.status !== exp_b.status) begin
          $error("status: expected %0d, got %0d", exp_b.status, res_if.status);
          n_fail++;
        end
      end
    end
  end

  // Hang watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HangLimit) begin
        $display("png_chunk_framer_crc32_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    chunk_req_t  r;
    int unsigned n_sent;
    logic [30:0] len;

    // Directed rows: extremes of type and data, empty chunks, one-byte
    // chunks, and both rejections (data with nothing open, begin mid-chunk).
    directed_tbl = '{
      '{CMD_DATA,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h5A, 1'b1, STATUS_NO_CHUNK},   // after reset
      '{CMD_BEGIN, 32'h4945_4E44, 31'd0,         8'hFF, 1'b0, STATUS_OK},         // IEND, empty
      '{CMD_BEGIN, 32'h0000_0000, 31'd0,         8'h00, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'hFFFF_FFFF, 31'd0,         8'h00, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'h4944_4154, 31'd1,         8'hFF, 1'b0, STATUS_OK},         // IDAT, 1 byte
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h00, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'hFF, 1'b1, STATUS_NO_CHUNK},   // after close
      '{CMD_BEGIN, 32'h7445_5874, 31'd3,         8'h00, 1'b0, STATUS_OK},         // tEXt, 3 bytes
      '{CMD_BEGIN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b1, STATUS_CHUNK_OPEN}, // mid-chunk
      '{CMD_DATA,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h00, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h1234_5678, 31'h0555_5555, 8'hA5, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'h4948_4452, 31'd2,         8'h00, 1'b0, STATUS_OK},         // IHDR, 2 bytes
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h80, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h01, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'hFFFF_FFFF, 31'd1,         8'h00, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'hFF, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'h0000_0000, 31'd2,         8'hFF, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h00, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h00, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'h8000_0001, 31'd0,         8'h00, 1'b0, STATUS_OK}
    };

    // Closing rows: a maximum-length chunk that is never finished, so every
    // length bit gets set; it is left open at the end on purpose.
    tail_tbl = '{
      '{CMD_BEGIN, 32'h89AB_CDEF, 31'h7FFF_FFFF, 8'h00, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'h3C, 1'b0, STATUS_OK},
      '{CMD_DATA,  32'h0000_0000, 31'd0,         8'hC3, 1'b0, STATUS_OK},
      '{CMD_BEGIN, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b1, STATUS_CHUNK_OPEN}
    };

    frame_crc    = CrcPreset;
    frame_left   = '0;
    frame_open   = 1'b0;
    n_fail       = 0;
    idle_cycles  = 0;
    send_burst   = 1'b0;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_BEGIN;
    req_if.chunk_type   = '0;
    req_if.chunk_length = '0;
    req_if.data_byte    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) send_req(directed_tbl[i]);

    // Let everything drain once before the random part.
    hold_until_drained();

    // Random part: mostly well-formed chunks with random content; stray
    // begins inside chunks and stray data between them as noise. Only
    // requests the block acts on count toward the total.
    n_sent = 0;
    while (n_sent < RandomRequests) begin
      send_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) hold_until_drained();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_req(rand_req(CMD_DATA, 31'($urandom)));
        end
      end
      len = pick_len();
      send_req(rand_req(CMD_BEGIN, len));
      n_sent++;
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          r = rand_req(CMD_BEGIN, 31'($urandom));
          send_req(r);
        end
        send_req(rand_req(CMD_DATA, 31'($urandom)));
        n_sent++;
      end
    end

    send_burst = 1'b0;
    foreach (tail_tbl[i]) send_req(tail_tbl[i]);

    // Watchdog bounds this wait; a missing byte ends as a hang.
    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("png_chunk_framer_crc32_tb: PASS");
    end else begin
      $display("png_chunk_framer_crc32_tb: FAIL");
    end
    $finish;
  end

endmodule

### png_chunk_framer_crc32.f
rtl/core/png_cf_pkg.sv
rtl/core/png_cf_in_if.sv
rtl/core/png_cf_out_if.sv
rtl/core/png_cf_step.sv
rtl/core/png_cf_ser.sv
rtl/core/png_chunk_framer_crc32.sv
test/png_chunk_framer_crc32_tb.sv
